// ===== rtl/assert_macros.svh =====
// Assertion helpers for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HHRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HHRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hhrc_pkg.sv =====
package hhrc_pkg;

    // Field widths of the pixel channels and the register port.
    localparam int HUE_W   = 15;
    localparam int COMP_W  = 16;
    localparam int X_W     = 16;
    localparam int FRAC_W  = 12;
    localparam int SECT_W  = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index is taken from this address bit (registers are 4 bytes apart).
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_SOURCE_SPACE = 1'b0;

    // Hue landmarks in 1/64 degree.
    localparam logic [X_W-1:0] SIXTH      = 16'd3840;
    localparam logic [X_W-1:0] THIRD      = 16'd7680;
    localparam logic [X_W-1:0] HALF_TURN  = 16'd11520;
    localparam logic [X_W-1:0] TWO_THIRDS = 16'd15360;
    localparam logic [X_W-1:0] CIRCLE     = 16'd23040;

    // Highest sector a 15-bit hue can reach.
    localparam int MAX_SECTOR = 8;

    // HSV sectors with their own channel routing; all others share one routing.
    localparam logic [SECT_W-1:0] SECT_YEL_GRN = 4'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN = 4'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU = 4'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG = 4'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED = 4'd5;

    typedef enum logic {
        SPACE_HSV = 1'b0,
        SPACE_HSL = 1'b1
    } t_space;

endpackage

// ===== rtl/hhrc_in_if.sv =====
interface hhrc_in_if;

    logic                         valid;
    logic                         ready;
    logic [hhrc_pkg::HUE_W-1:0]   hue;
    logic [hhrc_pkg::COMP_W-1:0]  saturation;
    logic [hhrc_pkg::COMP_W-1:0]  level;
    logic [hhrc_pkg::COMP_W-1:0]  opacity_in;

    modport source (
        output valid, hue, saturation, level, opacity_in,
        input  ready
    );

    modport sink (
        input  valid, hue, saturation, level, opacity_in,
        output ready
    );

endinterface

// ===== rtl/hhrc_out_if.sv =====
interface hhrc_out_if;

    logic                         valid;
    logic                         ready;
    logic [hhrc_pkg::COMP_W-1:0]  red;
    logic [hhrc_pkg::COMP_W-1:0]  green;
    logic [hhrc_pkg::COMP_W-1:0]  blue;
    logic [hhrc_pkg::COMP_W-1:0]  opacity_out;

    modport source (
        output valid, red, green, blue, opacity_out,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, opacity_out,
        output ready
    );

endinterface

// ===== rtl/hsv_hsl_to_rgb_converter_unit.sv =====
// Throughput: one pixel per cycle while the output takes results; seven register stages (hue
// decode, two multiply levels, numerator select, and a three-stage reciprocal divider) each
// take one pixel on the way from an accepted input transfer to the output register.
// A stalled output only holds the stages behind it that are full; empty stages keep filling.
// Reset (synchronous, active low) clears every stage valid bit and selects HSV.
`include "assert_macros.svh"

module hsv_hsl_to_rgb_converter_unit #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hhrc_in_if.sink                           i_pix,
    hhrc_out_if.source                        o_pix,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hhrc_pkg::PADDR_W-1:0]      paddr,
    input  logic [hhrc_pkg::PDATA_W-1:0]      pwdata,
    output logic [hhrc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    // Widths and scale constants derived from the component width.
    localparam int W     = COMPONENT_BITS;
    localparam int W2    = 2 * W;
    localparam int L2    = W2 + 2;
    localparam int DF_W  = W2 + 1;
    localparam int FW    = hhrc_pkg::FRAC_W;
    localparam int DEN_W = W + FW;
    localparam int Y_W   = W2 + FW;
    localparam int R_W   = DEN_W + 2;
    localparam int NST   = 7;

    localparam logic [63:0] FS64    = (64'd1 << W) - 64'd1;
    localparam logic [63:0] DEN64   = FS64 * 64'd3840;
    localparam int          SH      = $clog2(DEN64 + 64'd1) - 1;
    localparam int          YH_W    = Y_W - SH;
    localparam int          PR_W    = 2 * YH_W;
    localparam logic [63:0] RECIP64 = (64'd1 << Y_W) / DEN64;

    localparam logic [W-1:0]     FS     = FS64[W-1:0];
    localparam logic [DEN_W-1:0] DEN    = DEN64[DEN_W-1:0];
    localparam logic [Y_W-1:0]   HALF   = Y_W'(DEN64 >> 1);
    localparam logic [YH_W-1:0]  RECIP  = RECIP64[YH_W-1:0];
    localparam logic [R_W-1:0]   DEN_R  = R_W'(DEN64);
    localparam logic [R_W-1:0]   DEN2_R = R_W'(DEN64 * 64'd2);
    localparam logic [R_W-1:0]   DEN3_R = R_W'(DEN64 * 64'd3);

    // Position on an HSL trapezoid ramp, as a weight of t2 over t1 out of one sixth.
    function automatic logic [FW-1:0] ramp_weight(input logic [hhrc_pkg::X_W-1:0] x);
        logic [FW-1:0] wt;
        if (x < hhrc_pkg::SIXTH) begin
            wt = FW'(x);
        end else if (x < hhrc_pkg::HALF_TURN) begin
            wt = FW'(hhrc_pkg::SIXTH);
        end else if (x < hhrc_pkg::TWO_THIRDS) begin
            wt = FW'(hhrc_pkg::TWO_THIRDS - x);
        end else begin
            wt = '0;
        end
        return wt;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    hhrc_pkg::t_space r_source_space;

    assign pready = 1'b1;
    assign prdata = (paddr[hhrc_pkg::REG_IDX_BIT] == hhrc_pkg::REG_SOURCE_SPACE) ?
                    {{(hhrc_pkg::PDATA_W-1){1'b0}}, r_source_space} : '0;

    // The source space register takes the write on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_space <= hhrc_pkg::SPACE_HSV;
        end else if (psel && penable && pwrite && pready &&
                     paddr[hhrc_pkg::REG_IDX_BIT] == hhrc_pkg::REG_SOURCE_SPACE) begin
            r_source_space <= hhrc_pkg::t_space'(pwdata[0]);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or moving on.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || o_pix.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hue decode, ramp weights and the lightness-saturation product.
    // ------------------------------------------------------------------
    logic [W-1:0]                   n_s_in, n_l_in, n_a_in;
    logic [hhrc_pkg::SECT_W-1:0]    n1_sect;
    logic [hhrc_pkg::HUE_W-1:0]     n1_base;
    logic [hhrc_pkg::X_W-1:0]       n1_hue_x, n1_xr_sum, n1_xr, n1_xb;

    assign n_s_in = W'(i_pix.saturation);
    assign n_l_in = W'(i_pix.level);
    assign n_a_in = W'(i_pix.opacity_in);

    // Sector by comparison against each multiple of sixty degrees.
    always_comb begin
        n1_sect = '0;
        n1_base = '0;
        for (int k = 1; k <= hhrc_pkg::MAX_SECTOR; k++) begin
            if (i_pix.hue >= hhrc_pkg::HUE_W'(k * hhrc_pkg::SIXTH)) begin
                n1_sect = hhrc_pkg::SECT_W'(k);
                n1_base = hhrc_pkg::HUE_W'(k * hhrc_pkg::SIXTH);
            end
        end
    end

    // Red and blue ramps are the green ramp shifted by a third of a turn.
    assign n1_hue_x  = hhrc_pkg::X_W'(i_pix.hue);
    assign n1_xr_sum = n1_hue_x + hhrc_pkg::THIRD;
    assign n1_xr     = (n1_xr_sum > hhrc_pkg::CIRCLE) ? n1_xr_sum - hhrc_pkg::CIRCLE : n1_xr_sum;
    assign n1_xb     = (n1_hue_x >= hhrc_pkg::THIRD) ? n1_hue_x - hhrc_pkg::THIRD :
                       n1_hue_x + (hhrc_pkg::CIRCLE - hhrc_pkg::THIRD);

    logic [hhrc_pkg::SECT_W-1:0] r1_sect;
    logic [FW-1:0]               r1_f;
    logic [FW-1:0]               r1_wt [3];
    logic [W-1:0]                r1_s, r1_l, r1_a;
    logic [W2-1:0]               r1_ls;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_sect  <= n1_sect;
            r1_f     <= FW'(i_pix.hue - n1_base);
            r1_wt[0] <= ramp_weight(n1_xr);
            r1_wt[1] <= ramp_weight(n1_hue_x);
            r1_wt[2] <= ramp_weight(n1_xb);
            r1_s     <= n_s_in;
            r1_l     <= n_l_in;
            r1_a     <= n_a_in;
            r1_ls    <= W2'(n_l_in) * W2'(n_s_in);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: HSV scale factors and the HSL t1 level and ramp height.
    // ------------------------------------------------------------------
    logic [FW-1:0]    n2_fc;
    logic [DEN_W-1:0] n2_cq, n2_ct;
    logic [W2-1:0]    n2_pb;
    logic [L2-1:0]    n2_lfs, n2_sfs, n2_ls, n2_t1_full, n2_diff_full;
    logic             n2_dark;

    assign n2_fc = FW'(hhrc_pkg::SIXTH) - r1_f;
    assign n2_cq = DEN - DEN_W'(r1_s) * DEN_W'(r1_f);
    assign n2_ct = DEN - DEN_W'(r1_s) * DEN_W'(n2_fc);
    assign n2_pb = W2'(r1_l) * W2'(FS - r1_s);

    assign n2_lfs  = (L2'(r1_l) << W) - L2'(r1_l);
    assign n2_sfs  = (L2'(r1_s) << W) - L2'(r1_s);
    assign n2_ls   = L2'(r1_ls);
    assign n2_dark = (L2'(r1_l) << 1) < L2'(FS);

    // Below half lightness t2 = l(1+s), above it t2 = l + s(1-l); t1 = 2l - t2.
    always_comb begin
        if (n2_dark) begin
            n2_t1_full   = n2_lfs - n2_ls;
            n2_diff_full = n2_ls << 1;
        end else begin
            n2_t1_full   = n2_lfs - n2_sfs + n2_ls;
            n2_diff_full = (n2_sfs - n2_ls) << 1;
        end
    end

    logic [hhrc_pkg::SECT_W-1:0] r2_sect;
    logic [FW-1:0]               r2_wt [3];
    logic [W-1:0]                r2_l, r2_a;
    logic                        r2_grey;
    logic [DEN_W-1:0]            r2_cq, r2_ct;
    logic [W2-1:0]               r2_pb, r2_t1;
    logic [DF_W-1:0]             r2_diff;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_sect <= r1_sect;
            r2_wt   <= r1_wt;
            r2_l    <= r1_l;
            r2_a    <= r1_a;
            r2_grey <= (r1_s == '0);
            r2_cq   <= n2_cq;
            r2_ct   <= n2_ct;
            r2_pb   <= n2_pb;
            r2_t1   <= W2'(n2_t1_full);
            r2_diff <= DF_W'(n2_diff_full);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerators at the common scale of full scale times a sixth.
    // ------------------------------------------------------------------
    logic [hhrc_pkg::SECT_W-1:0] r3_sect;
    logic [W-1:0]                r3_a;
    logic                        r3_grey;
    logic [Y_W-1:0]              r3_v, r3_p, r3_q, r3_t, r3_t1;
    logic [Y_W-1:0]              r3_ramp [3];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_sect <= r2_sect;
            r3_a    <= r2_a;
            r3_grey <= r2_grey;
            r3_v    <= Y_W'(r2_l) * Y_W'(DEN);
            r3_p    <= Y_W'(r2_pb) * Y_W'(hhrc_pkg::SIXTH);
            r3_q    <= Y_W'(r2_l) * Y_W'(r2_cq);
            r3_t    <= Y_W'(r2_l) * Y_W'(r2_ct);
            r3_t1   <= Y_W'(r2_t1) * Y_W'(hhrc_pkg::SIXTH);
            for (int k = 0; k < 3; k++) begin
                r3_ramp[k] <= Y_W'(r2_diff) * Y_W'(r2_wt[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: route numerators to channels and add half the divisor.
    // ------------------------------------------------------------------
    logic [Y_W-1:0] n4_num [3];

    always_comb begin
        if (r_source_space == hhrc_pkg::SPACE_HSV) begin
            case (r3_sect)
                hhrc_pkg::SECT_YEL_GRN: begin
                    n4_num[0] = r3_q; n4_num[1] = r3_v; n4_num[2] = r3_p;
                end
                hhrc_pkg::SECT_GRN_CYN: begin
                    n4_num[0] = r3_p; n4_num[1] = r3_v; n4_num[2] = r3_t;
                end
                hhrc_pkg::SECT_CYN_BLU: begin
                    n4_num[0] = r3_p; n4_num[1] = r3_q; n4_num[2] = r3_v;
                end
                hhrc_pkg::SECT_BLU_MAG: begin
                    n4_num[0] = r3_t; n4_num[1] = r3_p; n4_num[2] = r3_v;
                end
                hhrc_pkg::SECT_MAG_RED: begin
                    n4_num[0] = r3_v; n4_num[1] = r3_p; n4_num[2] = r3_q;
                end
                default: begin
                    n4_num[0] = r3_v; n4_num[1] = r3_t; n4_num[2] = r3_p;
                end
            endcase
        end else if (r3_grey) begin
            // Zero saturation gives grey at the lightness.
            for (int k = 0; k < 3; k++) begin
                n4_num[k] = r3_v;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                n4_num[k] = r3_t1 + r3_ramp[k];
            end
        end
    end

    logic [W-1:0]   r4_a;
    logic [Y_W-1:0] r4_y [3];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_a <= r3_a;
            for (int k = 0; k < 3; k++) begin
                r4_y[k] <= n4_num[k] + HALF;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: quotient estimate from the top bits times the reciprocal.
    // ------------------------------------------------------------------
    logic [W-1:0]  r5_a;
    logic [PR_W-1:0] r5_prod [3];
    logic [R_W-1:0]  r5_ylo [3];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_a <= r4_a;
            for (int k = 0; k < 3; k++) begin
                r5_prod[k] <= PR_W'(r4_y[k][Y_W-1 -: YH_W]) * PR_W'(RECIP);
                r5_ylo[k]  <= r4_y[k][R_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: remainder of the estimate; the estimate is at most two short.
    // ------------------------------------------------------------------
    logic [W-1:0] n6_est [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n6_est[k] = r5_prod[k][YH_W +: W];
        end
    end

    logic [W-1:0]   r6_a;
    logic [W-1:0]   r6_est [3];
    logic [R_W-1:0] r6_rem [3];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_a <= r5_a;
            for (int k = 0; k < 3; k++) begin
                r6_est[k] <= n6_est[k];
                r6_rem[k] <= r5_ylo[k] - R_W'(R_W'(n6_est[k]) * DEN_R);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: correct the estimate, clamp and present the result.
    // ------------------------------------------------------------------
    logic [W:0]   n7_q [3];
    logic [W-1:0] n7_qc [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r6_rem[k] >= DEN2_R) begin
                n7_q[k] = (W+1)'(r6_est[k]) + (W+1)'(2);
            end else if (r6_rem[k] >= DEN_R) begin
                n7_q[k] = (W+1)'(r6_est[k]) + (W+1)'(1);
            end else begin
                n7_q[k] = (W+1)'(r6_est[k]);
            end
            n7_qc[k] = (n7_q[k] > (W+1)'(FS)) ? FS : n7_q[k][W-1:0];
        end
    end

    logic [hhrc_pkg::COMP_W-1:0] r7_rgb [3];
    logic [hhrc_pkg::COMP_W-1:0] r7_a;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_a <= hhrc_pkg::COMP_W'(r6_a);
            for (int k = 0; k < 3; k++) begin
                r7_rgb[k] <= hhrc_pkg::COMP_W'(n7_qc[k]);
            end
        end
    end

    assign o_pix.valid       = r_vld[NST-1];
    assign o_pix.red         = r7_rgb[0];
    assign o_pix.green       = r7_rgb[1];
    assign o_pix.blue        = r7_rgb[2];
    assign o_pix.opacity_out = r7_a;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Any empty stage lets the pipeline take a new transfer.
    `HHRC_ASSERT_IMP(a_ready_with_room, i_clk, i_rst_n, $countones(r_vld) < NST, i_pix.ready, "input refused while a stage is empty")

    // A full stage that is held keeps its item for the next cycle.
    `HHRC_ASSERT_NXT(a_held_stage_keeps_item, i_clk, i_rst_n, (r_vld & ~w_en) != '0, (r_vld & $past(r_vld & ~w_en)) == $past(r_vld & ~w_en), "held pipeline stage lost its item")

    // The reciprocal estimate is never more than two below the true quotient.
    `HHRC_ASSERT_IMP(a_divider_remainder_range, i_clk, i_rst_n, r_vld[5], (r6_rem[0] < DEN3_R) && (r6_rem[1] < DEN3_R) && (r6_rem[2] < DEN3_R), "divider remainder out of correction range")

endmodule
